FILE: src/dcms_pkg.sv
// ---------------------------------------------------------------------------
// dcms_pkg: shared types, constants and operation program
// Grid geometry, history word layout, job record handed from front to back,
// configuration record, and the operation list run by the arithmetic back end.
// ---------------------------------------------------------------------------
package dcms_pkg;

   localparam int COL_LEN = 64;
   localparam int COL_CNT = 64;
   localparam int VAL_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int ROW_W   = $clog2(COL_LEN);
   localparam int COL_W   = $clog2(COL_CNT + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int PROG_LEN  = 112;
   localparam int PC_W      = $clog2(PROG_LEN);
   localparam int TMP_DEPTH = 16;
   localparam int TMP_AW    = $clog2(TMP_DEPTH);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GY      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 3'd7;

   typedef logic signed [VAL_W-1:0] value_type;

   typedef struct packed {
      value_type   u_new;
      value_type   v_new;
      value_type   t_new;
      logic [1:0]  m_new;
      value_type   u_old;
      value_type   v_old;
   } hist_word_type;

   typedef struct packed {
      value_type u_c;
      value_type v_c;
      value_type t_c;
      value_type u_n;
      value_type v_n;
      value_type t_n;
      value_type u_s;
      value_type v_s;
      value_type v_se;
      value_type u_w;
      value_type v_w;
      value_type u_nw;
      value_type u_e;
      value_type v_e;
      value_type t_e;
      logic      f_upd;
      logic      g_upd;
      logic      done;
   } job_type;

   typedef struct packed {
      logic [30:0]  inv_re;
      logic [30:0]  dt;
      logic [30:0]  inv_dx;
      logic [30:0]  inv_dy;
      logic [16:0]  alpha;
      value_type    gx;
      value_type    gy;
      value_type    beta;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_ABS, OP_MUL, OP_SHR2, OP_SHR1
   } op_kind_type;

   // codes below SRC_FIXED_BASE live in the scratch memory
   localparam logic [5:0] SRC_FIXED_BASE = 6'd16;

   typedef enum logic [5:0] {
      R_A = 6'd0, R_B = 6'd1, R_P = 6'd2, R_Q = 6'd3, R_D1 = 6'd4, R_D2 = 6'd5,
      R_CX = 6'd6, R_CY = 6'd7, R_S0 = 6'd8, R_S1 = 6'd9, R_S2 = 6'd10, R_S3 = 6'd11,
      R_FR = 6'd12, R_GR = 6'd13,
      S_UC = 6'd16, S_VC = 6'd17, S_TC = 6'd18, S_UN = 6'd19, S_VN = 6'd20,
      S_TN = 6'd21, S_US = 6'd22, S_VS = 6'd23, S_VSE = 6'd24, S_UW = 6'd25,
      S_VW = 6'd26, S_UNW = 6'd27, S_UE = 6'd28, S_VE = 6'd29, S_TE = 6'd30,
      S_RE = 6'd31, S_DT = 6'd32, S_IDX = 6'd33, S_IDY = 6'd34, S_ALPHA = 6'd35,
      S_GX = 6'd36, S_GY = 6'd37, S_BETA = 6'd38
   } src_type;

   typedef struct packed {
      op_kind_type kind;
      src_type     dst;
      src_type     a;
      src_type     b;
   } op_type;

   function automatic op_type mk(input op_kind_type k, input src_type d,
                                 input src_type a, input src_type b);
      op_type o;
      o.kind = k;
      o.dst  = d;
      o.a    = a;
      o.b    = b;
      return o;
   endfunction

   // donor-cell convective term, result into dst
   function automatic op_type conv_step(input int k, input src_type dst, input src_type idl,
                                        input src_type pa, input src_type qa,
                                        input src_type pb, input src_type qb,
                                        input src_type da, input src_type db);
      op_type o;
      case (k)
         0:       o = mk(OP_MUL,  R_S0, pa, qa);
         1:       o = mk(OP_MUL,  R_S1, pb, qb);
         2:       o = mk(OP_SUB,  R_S0, R_S0, R_S1);
         3:       o = mk(OP_ABS,  R_S1, pa, pa);
         4:       o = mk(OP_MUL,  R_S1, R_S1, da);
         5:       o = mk(OP_ABS,  R_S2, pb, pb);
         6:       o = mk(OP_MUL,  R_S2, R_S2, db);
         7:       o = mk(OP_SUB,  R_S1, R_S1, R_S2);
         8:       o = mk(OP_MUL,  R_S1, S_ALPHA, R_S1);
         9:       o = mk(OP_ADD,  R_S0, R_S0, R_S1);
         10:      o = mk(OP_SHR2, R_S0, R_S0, R_S0);
         default: o = mk(OP_MUL,  dst, idl, R_S0);
      endcase
      return o;
   endfunction

   // diffusion, convection, gravity and buoyancy into dst
   function automatic op_type mom_step(input int k, input src_type dst, input src_type c,
                                       input src_type w, input src_type e,
                                       input src_type s, input src_type n,
                                       input src_type g, input src_type t0,
                                       input src_type t1);
      op_type o;
      case (k)
         0:       o = mk(OP_ADD,  R_S0, c, c);
         1:       o = mk(OP_SUB,  R_S1, w, R_S0);
         2:       o = mk(OP_ADD,  R_S1, R_S1, e);
         3:       o = mk(OP_SUB,  R_S2, s, R_S0);
         4:       o = mk(OP_ADD,  R_S2, R_S2, n);
         5:       o = mk(OP_MUL,  R_S3, S_IDX, S_IDX);
         6:       o = mk(OP_MUL,  R_S1, R_S1, R_S3);
         7:       o = mk(OP_MUL,  R_S3, S_IDY, S_IDY);
         8:       o = mk(OP_MUL,  R_S2, R_S2, R_S3);
         9:       o = mk(OP_ADD,  R_S1, R_S1, R_S2);
         10:      o = mk(OP_MUL,  R_S1, S_RE, R_S1);
         11:      o = mk(OP_SUB,  R_S1, R_S1, R_CX);
         12:      o = mk(OP_SUB,  R_S1, R_S1, R_CY);
         13:      o = mk(OP_ADD,  R_S1, R_S1, g);
         14:      o = mk(OP_MUL,  R_S1, S_DT, R_S1);
         15:      o = mk(OP_ADD,  R_S1, c, R_S1);
         16:      o = mk(OP_MUL,  R_S2, g, S_BETA);
         17:      o = mk(OP_MUL,  R_S2, R_S2, S_DT);
         18:      o = mk(OP_ADD,  R_S3, t0, t1);
         19:      o = mk(OP_MUL,  R_S2, R_S2, R_S3);
         20:      o = mk(OP_SHR1, R_S2, R_S2, R_S2);
         default: o = mk(OP_SUB,  dst, R_S1, R_S2);
      endcase
      return o;
   endfunction

   // F program then G program
   function automatic op_type prog_op(input logic [PC_W-1:0] pc);
      int k;
      op_type o;
      k = int'(pc);
      if (k < 4) begin
         case (k)
            0:       o = mk(OP_ADD, R_A,  S_UE, S_UC);
            1:       o = mk(OP_ADD, R_B,  S_UW, S_UC);
            2:       o = mk(OP_SUB, R_D1, S_UC, S_UE);
            default: o = mk(OP_SUB, R_D2, S_UW, S_UC);
         endcase
      end else if (k < 16) begin
         o = conv_step(k - 4, R_CX, S_IDX, R_A, R_A, R_B, R_B, R_D1, R_D2);
      end else if (k < 22) begin
         case (k - 16)
            0:       o = mk(OP_ADD, R_A,  S_VC, S_VE);
            1:       o = mk(OP_ADD, R_B,  S_VS, S_VSE);
            2:       o = mk(OP_ADD, R_P,  S_UC, S_UN);
            3:       o = mk(OP_ADD, R_Q,  S_US, S_UC);
            4:       o = mk(OP_SUB, R_D1, S_UC, S_UN);
            default: o = mk(OP_SUB, R_D2, S_US, S_UC);
         endcase
      end else if (k < 34) begin
         o = conv_step(k - 22, R_CY, S_IDY, R_A, R_P, R_B, R_Q, R_D1, R_D2);
      end else if (k < 56) begin
         o = mom_step(k - 34, R_FR, S_UC, S_UW, S_UE, S_US, S_UN, S_GX, S_TC, S_TE);
      end else if (k < 62) begin
         case (k - 56)
            0:       o = mk(OP_ADD, R_A,  S_UC, S_UN);
            1:       o = mk(OP_ADD, R_B,  S_UW, S_UNW);
            2:       o = mk(OP_ADD, R_P,  S_VC, S_VE);
            3:       o = mk(OP_ADD, R_Q,  S_VW, S_VC);
            4:       o = mk(OP_SUB, R_D1, S_VC, S_VE);
            default: o = mk(OP_SUB, R_D2, S_VW, S_VC);
         endcase
      end else if (k < 74) begin
         o = conv_step(k - 62, R_CX, S_IDX, R_A, R_P, R_B, R_Q, R_D1, R_D2);
      end else if (k < 78) begin
         case (k - 74)
            0:       o = mk(OP_ADD, R_A,  S_VC, S_VN);
            1:       o = mk(OP_ADD, R_B,  S_VS, S_VC);
            2:       o = mk(OP_SUB, R_D1, S_VC, S_VN);
            default: o = mk(OP_SUB, R_D2, S_VS, S_VC);
         endcase
      end else if (k < 90) begin
         o = conv_step(k - 78, R_CY, S_IDY, R_A, R_A, R_B, R_B, R_D1, R_D2);
      end else begin
         o = mom_step(k - 90, R_GR, S_VC, S_VW, S_VE, S_VS, S_VN, S_GY, S_TC, S_TN);
      end
      return o;
   endfunction

endpackage

FILE: src/dcms_front.sv
// ---------------------------------------------------------------------------
// dcms_front: cell intake and neighbourhood gathering
// Tracks grid position, keeps two columns of history in a row-indexed memory
// and assembles the stencil for the lagged cell into a job record.
// ---------------------------------------------------------------------------
module dcms_front import dcms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  value_type       in_u,
   input  value_type       in_v,
   input  value_type       in_t,
   input  logic            in_fluid,
   input  logic            in_outflow,
   input  logic            in_flush,
   output logic            job_valid,
   input  logic            job_ready,
   output job_type         job
);

   typedef enum logic [1:0] {F_IDLE, F_NREAD, F_PUSH} state_type;

   state_type              state_ff;
   logic [COL_W-1:0]       col_ff;
   logic [ROW_W-1:0]       row_ff;
   value_type              e_u_ff, e_v_ff, e_t_ff;
   logic [1:0]             e_m_ff;
   value_type              prev_u_ff, prev_v_ff, prev_ve_ff;
   hist_word_type          cw_ff;
   hist_word_type          rdata_ff;
   hist_word_type          hist_mem [COL_LEN];
   hist_word_type          wr_word;
   logic [ROW_W-1:0]       rd_addr;
   logic                   has_w, has_n, has_s, pad, go, last_row;

   assign last_row = (row_ff == ROW_W'(COL_LEN - 1));
   assign has_w    = (col_ff >= COL_W'(2));
   assign has_n    = !last_row;
   assign has_s    = (row_ff != '0);
   assign pad      = (col_ff >= COL_W'(COL_CNT)) || in_flush;
   assign in_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_PUSH) && (col_ff != '0);
   assign go       = (state_ff == F_PUSH) && ((col_ff == '0) || job_ready);

   // north row stays on the read port while the job waits to be pushed
   always_comb begin
      if (state_ff != F_IDLE && has_n) rd_addr = row_ff + ROW_W'(1);
      else rd_addr = row_ff;
   end

   always_comb begin
      job.u_c   = cw_ff.u_new;
      job.v_c   = cw_ff.v_new;
      job.t_c   = cw_ff.t_new;
      job.u_w   = has_w ? cw_ff.u_old : '0;
      job.v_w   = has_w ? cw_ff.v_old : '0;
      job.u_n   = has_n ? rdata_ff.u_new : '0;
      job.v_n   = has_n ? rdata_ff.v_new : '0;
      job.t_n   = has_n ? rdata_ff.t_new : '0;
      job.u_nw  = (has_w && has_n) ? rdata_ff.u_old : '0;
      job.u_s   = has_s ? prev_u_ff : '0;
      job.v_s   = has_s ? prev_v_ff : '0;
      job.v_se  = has_s ? prev_ve_ff : '0;
      job.u_e   = e_u_ff;
      job.v_e   = e_v_ff;
      job.t_e   = e_t_ff;
      job.f_upd = cw_ff.m_new[0] && (e_m_ff != 2'b00);
      job.g_upd = cw_ff.m_new[0] && has_n && rdata_ff.m_new[0];
      job.done  = (col_ff >= COL_W'(COL_CNT)) && last_row;
   end

   always_comb begin
      wr_word.u_new = e_u_ff;
      wr_word.v_new = e_v_ff;
      wr_word.t_new = e_t_ff;
      wr_word.m_new = e_m_ff;
      wr_word.u_old = cw_ff.u_new;
      wr_word.v_old = cw_ff.v_new;
   end

   // history: one row holds the previous column and the one before it
   always_ff @(posedge clock) begin
      rdata_ff <= hist_mem[rd_addr];
      if (go) hist_mem[row_ff] <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (in_valid) begin
                  e_u_ff   <= pad ? '0 : in_u;
                  e_v_ff   <= pad ? '0 : in_v;
                  e_t_ff   <= pad ? '0 : in_t;
                  e_m_ff   <= pad ? 2'b00 : {in_outflow, in_fluid};
                  state_ff <= F_NREAD;
               end
            end
            F_NREAD: begin
               cw_ff    <= rdata_ff;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (go) begin
                  prev_u_ff  <= cw_ff.u_new;
                  prev_v_ff  <= cw_ff.v_new;
                  prev_ve_ff <= e_v_ff;
                  if (last_row) begin
                     row_ff <= '0;
                     col_ff <= (col_ff >= COL_W'(COL_CNT)) ? '0 : col_ff + COL_W'(1);
                  end else begin
                     row_ff <= row_ff + ROW_W'(1);
                  end
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

FILE: src/dcms_queue.sv
// ---------------------------------------------------------------------------
// dcms_queue: job queue between front and back
// Small register queue so intake and arithmetic stall independently.
// ---------------------------------------------------------------------------
module dcms_queue import dcms_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  job_type  push_data,
   output logic     pop_valid,
   input  logic     pop,
   output job_type  head
);

   job_type                 slots [Q_DEPTH];
   logic [Q_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]      cnt_ff;
   logic                    do_push, do_pop;

   assign push_ready = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign head       = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) slots[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + Q_CNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - Q_CNT_W'(1);
      end
   end

endmodule

FILE: src/dcms_back.sv
// ---------------------------------------------------------------------------
// dcms_back: F and G evaluation
// Steps through the operation program on one shared saturating add/multiply
// unit with a small scratch memory, then loads the result register.
// ---------------------------------------------------------------------------
module dcms_back import dcms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output value_type  out_f,
   output value_type  out_g,
   output logic       out_f_upd,
   output logic       out_g_upd,
   output logic       out_done
);

   typedef enum logic [1:0] {B_IDLE, B_READ, B_EXEC, B_OUT} state_type;

   state_type          state_ff;
   logic [PC_W-1:0]    pc_ff;
   value_type          a_ff, b_ff;
   value_type          f_res_ff, g_res_ff;
   logic               out_valid_ff;
   value_type          out_f_ff, out_g_ff;
   logic               out_f_upd_ff, out_g_upd_ff, out_done_ff;
   value_type          tmp_mem [TMP_DEPTH];
   op_type             op;
   value_type          res;
   logic               load_out;

   logic signed [VAL_W:0]     sum_w, diff_w, neg_w;
   logic signed [2*VAL_W-1:0] prod, prod_sh;

   function automatic value_type sat_narrow(input logic signed [VAL_W:0] x);
      if (x[VAL_W] != x[VAL_W-1]) return x[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                   : {1'b0, {(VAL_W-1){1'b1}}};
      return x[VAL_W-1:0];
   endfunction

   function automatic value_type sat_wide(input logic signed [2*VAL_W-1:0] x);
      logic [VAL_W:0] hi;
      hi = x[2*VAL_W-1:VAL_W-1];
      if (!(&hi) && (|hi)) return x[2*VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                               : {1'b0, {(VAL_W-1){1'b1}}};
      return x[VAL_W-1:0];
   endfunction

   function automatic value_type fixed_src(input src_type s, input job_type j,
                                           input cfg_type c);
      value_type v;
      case (s)
         S_UC:    v = j.u_c;
         S_VC:    v = j.v_c;
         S_TC:    v = j.t_c;
         S_UN:    v = j.u_n;
         S_VN:    v = j.v_n;
         S_TN:    v = j.t_n;
         S_US:    v = j.u_s;
         S_VS:    v = j.v_s;
         S_VSE:   v = j.v_se;
         S_UW:    v = j.u_w;
         S_VW:    v = j.v_w;
         S_UNW:   v = j.u_nw;
         S_UE:    v = j.u_e;
         S_VE:    v = j.v_e;
         S_TE:    v = j.t_e;
         S_RE:    v = {{(VAL_W-31){1'b0}}, c.inv_re};
         S_DT:    v = {{(VAL_W-31){1'b0}}, c.dt};
         S_IDX:   v = {{(VAL_W-31){1'b0}}, c.inv_dx};
         S_IDY:   v = {{(VAL_W-31){1'b0}}, c.inv_dy};
         S_ALPHA: v = {{(VAL_W-17){1'b0}}, c.alpha};
         S_GX:    v = c.gx;
         S_GY:    v = c.gy;
         S_BETA:  v = c.beta;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign op = prog_op(pc_ff);

   assign sum_w   = {a_ff[VAL_W-1], a_ff} + {b_ff[VAL_W-1], b_ff};
   assign diff_w  = {a_ff[VAL_W-1], a_ff} - {b_ff[VAL_W-1], b_ff};
   assign neg_w   = -{a_ff[VAL_W-1], a_ff};
   assign prod    = a_ff * b_ff;
   assign prod_sh = prod >>> FRAC_W;

   always_comb begin
      case (op.kind)
         OP_ADD:  res = sat_narrow(sum_w);
         OP_SUB:  res = sat_narrow(diff_w);
         OP_ABS:  res = a_ff[VAL_W-1] ? sat_narrow(neg_w) : a_ff;
         OP_MUL:  res = sat_wide(prod_sh);
         OP_SHR2: res = a_ff >>> 2;
         OP_SHR1: res = a_ff >>> 1;
         default: res = '0;
      endcase
   end

   assign load_out  = (state_ff == B_OUT) && (!out_valid_ff || out_ready);
   assign job_pop   = load_out;
   assign out_valid = out_valid_ff;
   assign out_f     = out_f_ff;
   assign out_g     = out_g_ff;
   assign out_f_upd = out_f_upd_ff;
   assign out_g_upd = out_g_upd_ff;
   assign out_done  = out_done_ff;

   // scratch memory: two registered reads, one write
   always_ff @(posedge clock) begin
      if (state_ff == B_READ) begin
         a_ff <= (op.a < src_type'(SRC_FIXED_BASE)) ? tmp_mem[op.a[TMP_AW-1:0]]
                                                    : fixed_src(op.a, job, cfg);
         b_ff <= (op.b < src_type'(SRC_FIXED_BASE)) ? tmp_mem[op.b[TMP_AW-1:0]]
                                                    : fixed_src(op.b, job, cfg);
      end
      if (state_ff == B_EXEC) tmp_mem[op.dst[TMP_AW-1:0]] <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               pc_ff <= '0;
               if (job_valid) state_ff <= B_READ;
            end
            B_READ: state_ff <= B_EXEC;
            B_EXEC: begin
               if (op.dst == R_FR) f_res_ff <= res;
               if (op.dst == R_GR) g_res_ff <= res;
               if (pc_ff == PC_W'(PROG_LEN - 1)) begin
                  state_ff <= B_OUT;
               end else begin
                  pc_ff    <= pc_ff + PC_W'(1);
                  state_ff <= B_READ;
               end
            end
            B_OUT: begin
               if (load_out) begin
                  out_f_ff     <= job.f_upd ? f_res_ff : job.u_c;
                  out_g_ff     <= job.g_upd ? g_res_ff : job.v_c;
                  out_f_upd_ff <= job.f_upd;
                  out_g_upd_ff <= job.g_upd;
                  out_done_ff  <= job.done;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

FILE: src/donor_cell_momentum_stencil.sv
// A cell's result leaves only after the cell that follows it in the row has come in.
// The back end runs 112 saturating operations per cell, one at a time, on the single
//   shared multiply/add unit and takes a new cell once the last result is loaded.
// Cells of the first column produce no result and are not pushed to the queue.
// Reset: synchronous, active high; clears position, queue and handshake state and
//   loads the configuration defaults. History needs no clearing.
// ---------------------------------------------------------------------------
// donor_cell_momentum_stencil: F/G momentum stencil for a staggered grid
// Column-ordered cell stream in, F and G for the lagged cell out, with
// configuration registers written through the csr channel.
// ---------------------------------------------------------------------------
module donor_cell_momentum_stencil import dcms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*VAL_W-1:0]    req_tdata,   // u_velocity, v_velocity, temperature
   input  logic [2:0]            req_tuser,   // is_fluid, is_outflow, flush
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*VAL_W-1:0]    rsp_tdata,   // f_value, g_value
   output logic [1:0]            rsp_tuser,   // f_updated, g_updated
   output logic                  rsp_tlast,   // grid_done
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VAL_W-1:0]      csr_wdata
);

   cfg_type     cfg_ff;
   logic        job_valid, job_ready, q_valid, q_pop;
   job_type     job_in, job_head;
   value_type   out_f, out_g;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_re <= 31'd65536;
         cfg_ff.dt     <= '0;
         cfg_ff.inv_dx <= 31'd65536;
         cfg_ff.inv_dy <= 31'd65536;
         cfg_ff.alpha  <= '0;
         cfg_ff.gx     <= '0;
         cfg_ff.gy     <= '0;
         cfg_ff.beta   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INV_RE: cfg_ff.inv_re <= csr_wdata[30:0];
            CSR_DT:     cfg_ff.dt     <= csr_wdata[30:0];
            CSR_INV_DX: cfg_ff.inv_dx <= csr_wdata[30:0];
            CSR_INV_DY: cfg_ff.inv_dy <= csr_wdata[30:0];
            CSR_ALPHA:  cfg_ff.alpha  <= csr_wdata[16:0];
            CSR_GX:     cfg_ff.gx     <= csr_wdata;
            CSR_GY:     cfg_ff.gy     <= csr_wdata;
            CSR_BETA:   cfg_ff.beta   <= csr_wdata;
            default:    cfg_ff        <= cfg_ff;
         endcase
      end
   end

   dcms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_u       (req_tdata[VAL_W-1:0]),
      .in_v       (req_tdata[2*VAL_W-1:VAL_W]),
      .in_t       (req_tdata[3*VAL_W-1:2*VAL_W]),
      .in_fluid   (req_tuser[0]),
      .in_outflow (req_tuser[1]),
      .in_flush   (req_tuser[2]),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job_in)
   );

   dcms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_ready (job_ready),
      .push_data  (job_in),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .head       (job_head)
   );

   dcms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (q_valid),
      .job        (job_head),
      .job_pop    (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_f      (out_f),
      .out_g      (out_g),
      .out_f_upd  (rsp_tuser[0]),
      .out_g_upd  (rsp_tuser[1]),
      .out_done   (rsp_tlast)
   );

   assign rsp_tdata = {out_g, out_f};

endmodule
